[sv/prp_pkg.sv]
// Package for the puck rebound predictor.
// Holds register indexes, reset values and default widths; no dependencies.
package prp_pkg;
  localparam int POSITION_BITS_DEF = 14;
  localparam int SLOPE_FRACTION_BITS_DEF = 16;
  localparam int CFG_BITS = 14;
  localparam int STEP_BITS = 6;
  localparam logic [1:0] REG_TABLE_WIDTH = 2'd0;
  localparam logic [1:0] REG_TABLE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_STEPS = 2'd2;
  localparam logic [13:0] TABLE_WIDTH_RESET = 14'd4096;
  localparam logic [13:0] TABLE_HEIGHT_RESET = 14'd8192;
  localparam logic [5:0] MAX_STEPS_RESET = 6'd50;
endpackage

[sv/puck_rebound_predictor_core.sv]
// Puck rebound predictor, top level.
// Depends on prp_pkg for register indexes, reset values and default widths.
//
// Use: each input item (puck_x, puck_y) is a new measured puck position.
// With the previous position it gives a travel line that is traced inside
// the table, bouncing off the side walls and the near edge, until it meets
// the far edge or the step limit runs out. One result item (predicted_x,
// prediction_valid, bounce_count) follows each input item.
// Both channels use valid and stall. The block accepts one item at a time:
// in_stall is high from acceptance until the result item has been taken.
// The divisions and multiplies run through one shared shift unit, which
// retires one quotient bit per cycle when dividing, under a small
// sequencer. A non-vertical item takes a slope division; each trace step
// takes a serial multiply and, on an edge hit, a division of the same
// length, plus bookkeeping in the STEP and DECIDE states (and EDGE on an
// edge hit).
// Reset sets the registers to width 4096, height 8192, step limit 50 and
// the previous position to zero. A stalled result simply holds; no new
// item is taken until it leaves. Configuration is to be written only
// while idle; the user is bound by this, and the block itself does not
// enforce it.
module puck_rebound_predictor_core #(
  parameter int POSITION_BITS = prp_pkg::POSITION_BITS_DEF,
  parameter int SLOPE_FRACTION_BITS = prp_pkg::SLOPE_FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [prp_pkg::CFG_BITS-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [POSITION_BITS-1:0] puck_x,
  input  logic [POSITION_BITS-1:0] puck_y,
  output logic out_valid,
  input  logic out_stall,
  output logic [POSITION_BITS-1:0] predicted_x,
  output logic prediction_valid,
  output logic [prp_pkg::STEP_BITS-1:0] bounce_count
);
  localparam int P = POSITION_BITS;
  localparam int F = SLOPE_FRACTION_BITS;
  // Slope may reach (2^P-1)*2^F; products ax*m reach 2P+F bits.
  localparam int MB = P + F;
  localparam int WB = 2 * P + F + 1;
  localparam int NB = MB + 1;
  localparam int CB = $clog2(NB + 1);
  localparam int SB = prp_pkg::STEP_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SLOPE = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_MUL = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_EDGE = 3'd6;
  localparam logic [2:0] S_OUT = 3'd7;

  logic [2:0] state;
  logic [P-1:0] table_width, table_height;
  logic [SB-1:0] max_steps;
  logic [P-1:0] previous_x, previous_y;
  logic [P-1:0] px, py;
  logic right, up;
  logic [MB-1:0] slope;
  logic [SB-1:0] step;
  logic [P-1:0] ax, by;
  // Shared shift unit: acc is the remainder or product, quo the quotient or
  // multiplier, dvs the divisor or multiplicand.
  logic [WB-1:0] acc;
  logic [WB-1:0] quo;
  logic [WB-1:0] dvs;
  logic [CB-1:0] cnt;

  logic [WB-1:0] rem_shift;
  logic [WB-1:0] by_scaled;
  logic [P-1:0] ax_now, by_now;
  logic [P-1:0] xt, ay;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign rem_shift = {acc[WB-2:0], quo[WB-1]};
  assign by_scaled = WB'(by) << F;
  assign ax_now = right ? table_width - px : px;
  assign by_now = up ? table_height - py : py;
  // Quotient and product clamps to the remaining distance.
  assign xt = (quo > WB'(ax)) ? ax : quo[P-1:0];
  assign ay = ((acc >> F) > WB'(by)) ? by : acc[F+P-1:F];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      table_width <= P'(prp_pkg::TABLE_WIDTH_RESET);
      table_height <= P'(prp_pkg::TABLE_HEIGHT_RESET);
      max_steps <= prp_pkg::MAX_STEPS_RESET;
      previous_x <= '0;
      previous_y <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          prp_pkg::REG_TABLE_WIDTH: table_width <= P'(cfg_data);
          prp_pkg::REG_TABLE_HEIGHT: table_height <= P'(cfg_data);
          prp_pkg::REG_MAX_STEPS: max_steps <= SB'(cfg_data);
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            previous_x <= puck_x;
            previous_y <= puck_y;
            right <= puck_x > previous_x;
            up <= puck_y > previous_y;
            px <= (puck_x < table_width) ? puck_x : table_width;
            py <= (puck_y < table_height) ? puck_y : table_height;
            predicted_x <= '0;
            prediction_valid <= 1'b0;
            bounce_count <= '0;
            step <= SB'(1);
            acc <= '0;
            quo <= WB'((puck_y > previous_y) ? puck_y - previous_y
                                             : previous_y - puck_y) << (F + WB - MB);
            dvs <= WB'((puck_x > previous_x) ? puck_x - previous_x
                                             : previous_x - puck_x);
            cnt <= CB'(MB);
            state <= (puck_x == previous_x) ? S_OUT : S_SLOPE;
          end
        end
        S_SLOPE, S_DIV: begin
          // One restoring division bit per cycle.
          if (rem_shift >= dvs) begin
            acc <= rem_shift - dvs;
            quo <= {quo[WB-2:0], 1'b1};
          end else begin
            acc <= rem_shift;
            quo <= {quo[WB-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CB'(1)) begin
            if (state == S_SLOPE) begin
              slope <= (rem_shift >= dvs) ? {quo[MB-2:0], 1'b1} : {quo[MB-2:0], 1'b0};
              bounce_count <= max_steps;
              state <= S_STEP;
            end else begin
              state <= S_EDGE;
            end
          end
        end
        S_STEP: begin
          if (step >= max_steps) begin
            state <= S_OUT;
          end else begin
            ax <= ax_now;
            by <= by_now;
            acc <= '0;
            quo <= WB'(slope);
            dvs <= WB'(ax_now);
            cnt <= CB'(MB);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // Shift-add multiply, multiplier bits from the top.
          acc <= (acc << 1) + (quo[MB-1] ? dvs : '0);
          quo <= quo << 1;
          cnt <= cnt - 1'b1;
          if (cnt == CB'(1)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (slope != '0 && by_scaled <= acc) begin
            acc <= '0;
            quo <= by_scaled << (WB - P - F);
            dvs <= WB'(slope);
            cnt <= CB'(P + F);
            state <= S_DIV;
          end else begin
            py <= up ? py + ay : py - ay;
            px <= right ? table_width : '0;
            right <= !right;
            step <= step + 1'b1;
            state <= S_STEP;
          end
        end
        S_EDGE: begin
          if (up) begin
            predicted_x <= right ? px + xt : px - xt;
            prediction_valid <= 1'b1;
            bounce_count <= step;
            state <= S_OUT;
          end else begin
            px <= right ? px + xt : px - xt;
            py <= '0;
            up <= 1'b1;
            step <= step + 1'b1;
            state <= S_STEP;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/sv/tb.sv]
// Testbench for puck_rebound_predictor_core: directed table plus random positions.
// Depends on prp_pkg and the core; a behavioral predictor checks every result item.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = 14;
  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [PB-1:0] pred;
    logic          hit;
    logic [5:0]    steps;
  } rebound_t;

  // A directed row: the position, and when known, the expected result.
  typedef struct {
    logic [PB-1:0] x;
    logic [PB-1:0] y;
    bit            typed;
    rebound_t      res;
  } row_t;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = prp_pkg::REG_TABLE_WIDTH;
  logic [prp_pkg::CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic [PB-1:0] puck_x = '0, puck_y = '0;
  logic [PB-1:0] predicted_x;
  logic prediction_valid;
  logic [5:0] bounce_count;

  // Predictor state, mirrored from what the block holds.
  logic [PB-1:0] width_r, height_r, last_x, last_y;
  logic [5:0]    steps_r;

  rebound_t expected_q[$];
  row_t     rows[$];
  int       fails = 0;
  int       idle_cycles = 0;
  int       out_wait = 0;

  always #10 clk = ~clk;

  puck_rebound_predictor_core dut (.*);

  // Trace the line from the previous position to the new one across the table.
  function automatic rebound_t trace_rebound(logic [PB-1:0] nx, logic [PB-1:0] ny);
    rebound_t r;
    bit right, up, edge_hit;
    longint unsigned adx, ady, m, px, py, ax, by, xt, ay;
    logic [127:0] prod;
    r.pred = '0;
    r.hit = 0;
    r.steps = '0;
    if (nx != last_x) begin
      right = nx > last_x;
      adx = right ? nx - last_x : last_x - nx;
      up = ny > last_y;
      ady = up ? ny - last_y : last_y - ny;
      m = (ady << FB) / adx;
      px = nx < width_r ? nx : width_r;
      py = ny < height_r ? ny : height_r;
      r.steps = steps_r;
      for (int k = 1; k < steps_r; k++) begin
        ax = right ? width_r - px : px;
        by = up ? height_r - py : py;
        prod = 128'(ax) * 128'(m);
        edge_hit = (m != 0) && ((by << FB) <= prod);
        if (edge_hit) begin
          xt = (by << FB) / m;
          if (xt > ax) xt = ax;
          px = right ? px + xt : px - xt;
          if (up) begin
            r.hit = 1;
            r.pred = px[PB-1:0];
            r.steps = 6'(k);
            break;
          end
          py = 0;
          up = 1;
        end else begin
          ay = 64'(prod >> FB);
          if (ay > by) ay = by;
          py = up ? py + ay : py - ay;
          px = right ? width_r : 0;
          right = !right;
        end
      end
    end
    last_x = nx;
    last_y = ny;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= prp_pkg::CFG_BITS'(val);
    @(posedge clk);
    cfg_write <= 0;
    case (idx)
      prp_pkg::REG_TABLE_WIDTH:  width_r = PB'(val);
      prp_pkg::REG_TABLE_HEIGHT: height_r = PB'(val);
      default:                   steps_r = 6'(val);
    endcase
  endtask

  // Drive one item; the expectation is queued at the accepting edge.
  // in_valid stays high after acceptance until the next gap or a drain.
  task automatic send_position(logic [PB-1:0] x, logic [PB-1:0] y, bit typed, rebound_t res);
    rebound_t r;
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    puck_x <= x;
    puck_y <= y;
    do @(posedge clk); while (in_stall);
    r = trace_rebound(x, y);
    if (typed && r != res) begin
      $error("directed row (%0d,%0d) disagrees with the predictor", x, y);
      fails++;
    end
    expected_q.push_back(typed ? res : r);
  endtask

  // Wait for every outstanding result, then a margin so the block is idle.
  task automatic drain;
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic rebound_t mk(int p, int h, int s);
    rebound_t r;
    r.pred = PB'(p);
    r.hit = h[0];
    r.steps = 6'(s);
    return r;
  endfunction

  function automatic void add_row(int x, int y, bit typed, rebound_t res);
    row_t w;
    w.x = PB'(x);
    w.y = PB'(y);
    w.typed = typed;
    w.res = res;
    rows.push_back(w);
  endfunction

  // Result side: a random wait between items, compare against the
  // oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_wait = 0;
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fails++;
        end else begin
          rebound_t e;
          e = expected_q.pop_front();
          if (predicted_x !== e.pred) begin
            $error("predicted_x expected %0d actual %0d", e.pred, predicted_x);
            fails++;
          end
          if (prediction_valid !== e.hit) begin
            $error("prediction_valid expected %0d actual %0d", e.hit, prediction_valid);
            fails++;
          end
          if (bounce_count !== e.steps) begin
            $error("bounce_count expected %0d actual %0d", e.steps, bounce_count);
            fails++;
          end
        end
        out_wait = $urandom_range(0, 8);
      end else if (out_valid && out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (out_wait != 0);
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  rebound_t none;

  initial begin
    width_r = prp_pkg::TABLE_WIDTH_RESET;
    height_r = prp_pkg::TABLE_HEIGHT_RESET;
    steps_r = prp_pkg::MAX_STEPS_RESET;
    last_x = '0;
    last_y = '0;
    none = mk(0, 0, 0);
    repeat (4) @(posedge clk);
    rst <= 0;

    // Directed rows at reset settings: vertical motion, straight shots to the
    // far edge, horizontal motion, steep and shallow lines, the field extremes
    // and starts outside the table.
    add_row(0, 100, 1, none);          // vertical from reset position
    add_row(100, 100, 0, none);        // horizontal: runs out of steps
    add_row(200, 4196, 0, none);
    add_row(100, 0, 0, none);          // moving down: near edge bounce
    add_row(16383, 16383, 0, none);    // start clamped outside
    add_row(0, 0, 0, none);
    add_row(16383, 0, 0, none);
    add_row(16383, 16383, 1, none);    // vertical at the extreme
    add_row(0, 16383, 0, none);        // horizontal along the top
    add_row(1, 0, 0, none);
    add_row(2, 16383, 0, none);        // very steep
    add_row(2048, 4096, 0, none);
    add_row(4096, 8192, 0, none);      // corner tie
    add_row(10922, 5461, 0, none);
    add_row(5461, 10922, 0, none);
    add_row(8191, 8191, 0, none);
    add_row(8192, 8192, 0, none);
    foreach (rows[i]) send_position(rows[i].x, rows[i].y, rows[i].typed, rows[i].res);
    drain();

    // Random phases over several table settings, the extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(prp_pkg::REG_TABLE_WIDTH, 1);
                 write_reg(prp_pkg::REG_TABLE_HEIGHT, 1);
                 write_reg(prp_pkg::REG_MAX_STEPS, 1); end
        1: begin write_reg(prp_pkg::REG_TABLE_WIDTH, 16383);
                 write_reg(prp_pkg::REG_TABLE_HEIGHT, 16383);
                 write_reg(prp_pkg::REG_MAX_STEPS, 63); end
        2: begin write_reg(prp_pkg::REG_TABLE_WIDTH, 300);
                 write_reg(prp_pkg::REG_TABLE_HEIGHT, 9000);
                 write_reg(prp_pkg::REG_MAX_STEPS, 20); end
        3: begin write_reg(prp_pkg::REG_TABLE_WIDTH, 12000);
                 write_reg(prp_pkg::REG_TABLE_HEIGHT, 500);
                 write_reg(prp_pkg::REG_MAX_STEPS, 2); end
        default: begin
          write_reg(prp_pkg::REG_TABLE_WIDTH, $urandom_range(1, 16383));
          write_reg(prp_pkg::REG_TABLE_HEIGHT, $urandom_range(1, 16383));
          write_reg(prp_pkg::REG_MAX_STEPS, $urandom_range(1, 63));
        end
      endcase
      for (int i = 0; i < 50; i++) begin
        logic [PB-1:0] nx, ny;
        // Mostly points anywhere inside the table; some vertical moves from the
        // last point and some anywhere across the full field range.
        case ($urandom_range(0, 3))
          0: begin nx = PB'($urandom); ny = PB'($urandom); end
          1: begin nx = last_x; ny = PB'($urandom); end
          default: begin
            nx = PB'($urandom_range(0, width_r));
            ny = PB'($urandom_range(0, height_r));
          end
        endcase
        send_position(nx, ny, 0, none);
      end
      drain();
    end
    repeat (100) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[sim.f]
sv/prp_pkg.sv
sv/puck_rebound_predictor_core.sv
tb/sv/tb.sv
